@@ hw/rtl/flw_pkg.sv @@
// shared types and constants for the four-connected line walker
// no dependencies; imported by flw_ctrl, flw_datapath and the core top level
`default_nettype none

package flw_pkg;

	// width of every coordinate port
	localparam int FIELD_BITS = 5;
	// default number of significant coordinate bits
	localparam int COORD_BITS_DEF = 5;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new line transaction
		logic step;   // advance to the next pixel
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last;   // current pixel is the end point
	} dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/flw_datapath.sv @@
// line walker datapath: endpoint swap, running position and slope error term
// depends on flw_pkg for the command and status structs
`default_nettype none

module flw_datapath #(
	parameter int COORD_BITS = flw_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire flw_pkg::dp_cmd_t              cmd,
	output flw_pkg::dp_sts_t                   sts,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] start_x,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] start_y,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] end_x,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] end_y,
	output logic [flw_pkg::FIELD_BITS-1:0]      pixel_x,
	output logic [flw_pkg::FIELD_BITS-1:0]      pixel_y
);
	import flw_pkg::*;

	// error = wy*dx - ady*wx, magnitude below 2^(2*COORD_BITS)
	localparam int ERR_BITS = 2 * COORD_BITS + 2;

	logic [COORD_BITS-1:0] sx, sy, ex, ey;
	logic                  swap;
	logic [COORD_BITS-1:0] ax, ay, bx, by;
	logic [COORD_BITS-1:0] dx_in, ady_in;
	logic                  down_in;

	logic [COORD_BITS-1:0]      cx_q, cy_q, rx_q, ry_q, dx_q, ady_q;
	logic                       down_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic signed [ERR_BITS-1:0] dx_ext, ady_ext;
	logic                       go_x;

	assign sx = start_x[COORD_BITS-1:0];
	assign sy = start_y[COORD_BITS-1:0];
	assign ex = end_x[COORD_BITS-1:0];
	assign ey = end_y[COORD_BITS-1:0];

	// order endpoints so x never decreases
	assign swap    = ex < sx;
	assign ax      = swap ? ex : sx;
	assign ay      = swap ? ey : sy;
	assign bx      = swap ? sx : ex;
	assign by      = swap ? sy : ey;
	assign dx_in   = bx - ax;
	assign down_in = by < ay;
	assign ady_in  = down_in ? (ay - by) : (by - ay);

	assign dx_ext  = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, dx_q});
	assign ady_ext = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, ady_q});

	// x step if x remains and y is done or the path so far is steeper than target
	assign go_x = (rx_q != '0) && ((ry_q == '0) || (err_q > 0));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q   <= ax;
			cy_q   <= ay;
			rx_q   <= dx_in;
			ry_q   <= ady_in;
			dx_q   <= dx_in;
			ady_q  <= ady_in;
			down_q <= down_in;
			err_q  <= '0;
		end else if (cmd.step) begin
			if (go_x) begin
				rx_q  <= rx_q - 1'b1;
				cx_q  <= cx_q + 1'b1;
				err_q <= err_q - ady_ext;
			end else begin
				ry_q  <= ry_q - 1'b1;
				cy_q  <= down_q ? (cy_q - 1'b1) : (cy_q + 1'b1);
				err_q <= err_q + dx_ext;
			end
		end
	end

	assign sts.last = (rx_q == '0) && (ry_q == '0);
	assign pixel_x  = FIELD_BITS'(cx_q);
	assign pixel_y  = FIELD_BITS'(cy_q);

endmodule

`default_nettype wire

@@ hw/rtl/flw_ctrl.sv @@
// line walker controller: accepts a line, then hands out one pixel per transaction
// depends on flw_pkg for the command and status structs
`default_nettype none

module flw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output flw_pkg::dp_cmd_t      cmd,
	input  wire flw_pkg::dp_sts_t sts
);
	import flw_pkg::*;

	typedef enum logic {
		IDLE,
		WALK
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = (state_q == WALK);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.step  = out_valid && out_ready && !sts.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) state_q <= WALK;
				end
				WALK: begin
					if (out_ready && sts.last) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// an accepted line always produces a pixel next cycle
	a_load_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("no pixel after line accepted");

	// taking the end pixel frees the input side
	a_last_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.last) |=> in_ready)
		else $error("not ready after end pixel");

	// a pixel that is not the end point is always followed by another
	a_more_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !sts.last) |=> out_valid)
		else $error("walk stopped before end point");

	// never loading and stepping at once
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step together");

endmodule

`default_nettype wire

@@ hw/rtl/four_connected_line_walker_core.sv @@
// top level of the four-connected line walker
// depends on flw_pkg, flw_ctrl and flw_datapath
`default_nettype none

// Takes one line transaction (two endpoints) and returns every pixel of a
// 4-connected staircase line from the left endpoint to the right one, one
// output transaction per pixel, with last_pixel set on the end point. If the
// second endpoint lies left of the first, the two are swapped. Each step moves
// one unit in x or one unit in y; the choice compares the path walked so far
// against the target slope with an exact integer error term, updated by one
// add or subtract per pixel. A line of dx + |dy| + 1 pixels is walked by first
// capturing the endpoints, then handing out one pixel per cycle while out_ready
// is high. The next line is taken only once the end pixel has been delivered.
// Coordinate bits at or above COORD_BITS are ignored; outputs are zero
// extended to the port width.
module four_connected_line_walker_core #(
	parameter int COORD_BITS = flw_pkg::COORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// line input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] start_x,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] start_y,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] end_x,
	input  wire logic [flw_pkg::FIELD_BITS-1:0] end_y,
	// pixel output channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [flw_pkg::FIELD_BITS-1:0]      pixel_x,
	output logic [flw_pkg::FIELD_BITS-1:0]      pixel_y,
	output logic                                last_pixel
);
	import flw_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: idle / walking
	flw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// position, remaining counts and slope error
	flw_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y)
	);

	// end point flag comes straight from the remaining counts
	assign last_pixel = sts.last;

endmodule

`default_nettype wire
